@@ rtl/aes_pkg.sv @@
// AES-128 package: S-box tables, GF(2^8) helpers and round functions.
`timescale 1ns / 1ps
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned HalfW     = 64;
  localparam int unsigned CfgIdxW   = 1;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [7:0]        byte_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  localparam logic [2047:0] SboxFlat = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] InvSboxFlat = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic byte_t sbox(input byte_t v);
    sbox = SboxFlat[2047 - 8*v -: 8];
  endfunction

  function automatic byte_t inv_sbox(input byte_t v);
    inv_sbox = InvSboxFlat[2047 - 8*v -: 8];
  endfunction

  function automatic byte_t xtime(input byte_t v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the block sits at bits 127-8i downto 120-8i.
  function automatic byte_t get_byte(input block_t s, input int unsigned i);
    get_byte = s[BlockW-1-8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[BlockW-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c+r)%4)));
      end
    end
    sub_shift = o;
  endfunction

  function automatic block_t inv_sub_shift(input block_t s);
    block_t o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[BlockW-1-8*(r+4*((c+r)%4)) -: 8] = inv_sbox(get_byte(s, r + 4*c));
      end
    end
    inv_sub_shift = o;
  endfunction

  function automatic block_t mix_cols(input block_t s);
    block_t o;
    byte_t  a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      o[BlockW-1-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[BlockW-1-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[BlockW-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[BlockW-1-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_cols = o;
  endfunction

  // Inverse mix: pre-multiply each column by {05,00,04,00} then forward mix.
  function automatic block_t inv_mix_cols(input block_t s);
    block_t p;
    byte_t  a0, a1, a2, a3, u, v;
    p = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      p[BlockW-1-8*(4*c)   -: 8] = a0 ^ u;
      p[BlockW-1-8*(4*c+1) -: 8] = a1 ^ v;
      p[BlockW-1-8*(4*c+2) -: 8] = a2 ^ u;
      p[BlockW-1-8*(4*c+3) -: 8] = a3 ^ v;
    end
    inv_mix_cols = mix_cols(p);
  endfunction

  // One key-schedule step: round key k-1 to round key k.
  function automatic block_t next_key(input block_t k, input byte_t rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

  function automatic byte_t rcon(input int unsigned k);
    byte_t r;
    r = 8'h01;
    for (int i = 1; i < 10; i++) begin
      if (i < k) r = xtime(r);
    end
    rcon = r;
  endfunction

endpackage

@@ rtl/aes128_block_cipher_core.sv @@
// Top level: AES-128 encrypt/decrypt pipeline with key registers.
`timescale 1ns / 1ps
// Fully pipelined AES-128: one block enters per cycle unless the output stalls
// or the key chain settles. The item passes twelve register stages: one input
// stage with the initial key add, ten round stages, and the output register.
// A stall on the output freezes the whole pipe, so nothing is lost or
// repeated. The round keys are expanded in a register chain from the key
// registers. After reset and after every key write, in_ready_o stays low
// while the expansion settles; after that, blocks can follow back to back.
// Register 0 holds key bytes 0 to 7, register 1 key bytes 8 to 15.
module aes128_block_cipher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aes_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [aes_pkg::HalfW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [aes_pkg::HalfW-1:0]     block_high_i,
  input  logic [aes_pkg::HalfW-1:0]     block_low_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [aes_pkg::HalfW-1:0]     result_high_o,
  output logic [aes_pkg::HalfW-1:0]     result_low_o
);
  localparam int unsigned N = aes_pkg::NumRounds;
  localparam logic [3:0] SettleCycles = 4'(N + 1);

  logic [aes_pkg::HalfW-1:0] key_hi_q, key_lo_q;
  aes_pkg::block_t [N:0] rk;
  logic en;
  logic in_acc;
  logic [3:0] settle_d, settle_q;

  logic [N:0]            v;
  logic [N:0]            cmd;
  aes_pkg::block_t [N:0] st;

  logic            v0_q, cmd0_q;
  aes_pkg::block_t st0_q, blk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (aes_pkg::cfg_reg_e'(cfg_index_i))
        aes_pkg::REG_KEY_HIGH: key_hi_q <= cfg_data_i;
        aes_pkg::REG_KEY_LOW:  key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold off input until the key chain has caught up with the key registers.
  always_comb begin
    settle_d = settle_q;
    if (cfg_we_i) begin
      settle_d = SettleCycles;
    end else if (settle_q != 4'd0) begin
      settle_d = settle_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleCycles;
    end else begin
      settle_q <= settle_d;
    end
  end

  aes_key_sched u_key_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       ({key_hi_q, key_lo_q}),
    .round_key_o (rk)
  );

  // Pipe advances unless the output holds an item nobody takes.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en && (settle_q == 4'd0);
  assign in_acc     = in_valid_i && in_ready_o;
  assign blk        = {block_high_i, block_low_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd0_q <= command_i;
      st0_q  <= blk ^ ((command_i == aes_pkg::CMD_DECRYPT) ? rk[N] : rk[0]);
    end
  end

  assign v[0]   = v0_q;
  assign cmd[0] = cmd0_q;
  assign st[0]  = st0_q;

  for (genvar r = 1; r <= N; r++) begin : g_round
    aes_round #(
      .LastRound (r == N)
    ) u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (v[r-1]),
      .cmd_i     (cmd[r-1]),
      .state_i   (st[r-1]),
      .enc_key_i (rk[r]),
      .dec_key_i (rk[N-r]),
      .valid_o   (v[r]),
      .cmd_o     (cmd[r]),
      .state_o   (st[r])
    );
  end

  logic            ov_q;
  aes_pkg::block_t ost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) ost_q <= st[N];
  end

  assign out_valid_o   = ov_q;
  assign result_high_o = ost_q[127:64];
  assign result_low_o  = ost_q[63:0];
endmodule

@@ rtl/aes_key_sched.sv @@
// Key schedule: expands the key registers into all eleven round keys.
`timescale 1ns / 1ps
module aes_key_sched (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  aes_pkg::block_t                     key_i,
  output aes_pkg::block_t [aes_pkg::NumRounds:0] round_key_o
);
  aes_pkg::block_t [aes_pkg::NumRounds:0] rk_q, rk_d;

  // The user must change keys only while idle (not enforced); rk is registered.
  always_comb begin
    rk_d[0] = key_i;
    for (int k = 1; k <= aes_pkg::NumRounds; k++) begin
      rk_d[k] = aes_pkg::next_key(rk_q[k-1], aes_pkg::rcon(k));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_q <= '0;
    end else begin
      rk_q <= rk_d;
    end
  end

  assign round_key_o = rk_q;
endmodule

@@ rtl/aes_round.sv @@
// One pipelined cipher round, encrypt or decrypt by the item's command.
`timescale 1ns / 1ps
module aes_round #(
  parameter bit LastRound = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic            cmd_i,
  input  aes_pkg::block_t state_i,
  input  aes_pkg::block_t enc_key_i,
  input  aes_pkg::block_t dec_key_i,
  output logic            valid_o,
  output logic            cmd_o,
  output aes_pkg::block_t state_o
);
  aes_pkg::block_t state_d, state_q;
  logic            valid_q, cmd_q;

  always_comb begin
    if (cmd_i == aes_pkg::CMD_DECRYPT) begin
      state_d = aes_pkg::inv_sub_shift(state_i) ^ dec_key_i;
      if (!LastRound) state_d = aes_pkg::inv_mix_cols(state_d);
    end else begin
      state_d = aes_pkg::sub_shift(state_i);
      if (!LastRound) state_d = aes_pkg::mix_cols(state_d);
      state_d = state_d ^ enc_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      cmd_q   <= cmd_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;
  assign state_o = state_q;
endmodule

@@ tb/aes128_block_cipher_core_tb.sv @@
// Testbench for the AES-128 encrypt/decrypt pipeline with self-checking predictor.
`timescale 1ns / 1ps
module aes128_block_cipher_core_tb;

  typedef struct {
    logic            load_key;
    logic [63:0]     key_hi;
    logic [63:0]     key_lo;
    aes_pkg::cmd_e   cmd;
    logic [63:0]     blk_hi;
    logic [63:0]     blk_lo;
    logic            known;
    logic [63:0]     res_hi;
    logic [63:0]     res_lo;
  } vec_row_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [aes_pkg::CfgIdxW-1:0] cfg_index_i = aes_pkg::REG_KEY_HIGH;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = aes_pkg::CMD_ENCRYPT;
  logic [63:0] block_high_i = '0;
  logic [63:0] block_low_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;

  aes128_block_cipher_core uut (.*);

  always #2 clk_i = ~clk_i;

  logic [7:0]   fwd_tab[256];
  logic [7:0]   inv_tab[256];
  logic [127:0] cur_key = '0;
  cipher_out_t  pending_blocks[$];
  int           errors = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           hold_req = 0;
  int           hold_seen = 0;
  int           hold_left = 0;

  function automatic logic [7:0] gf_mult(logic [7:0] x, logic [7:0] y);
    logic [7:0] p;
    p = '0;
    for (int n = 0; n < 8; n++) begin
      if (y[0]) p ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      y = y >> 1;
    end
    return p;
  endfunction

  task automatic build_sub_tables();
    logic [7:0] acc, base, iv;
    for (int v = 0; v < 256; v++) begin
      iv = '0;
      if (v != 0) begin
        acc = 8'h01;
        base = v[7:0];
        for (int n = 0; n < 8; n++) begin
          if ((254 >> n) & 1) acc = gf_mult(acc, base);
          base = gf_mult(base, base);
        end
        iv = acc;
      end
      fwd_tab[v] = iv ^ {iv[6:0], iv[7]} ^ {iv[5:0], iv[7:6]} ^ {iv[4:0], iv[7:5]}
                   ^ {iv[3:0], iv[7:4]} ^ 8'h63;
    end
    for (int v = 0; v < 256; v++) inv_tab[fwd_tab[v]] = v[7:0];
  endtask

  function automatic logic [127:0] sub_rows(logic [127:0] s, logic inverse);
    logic [127:0] o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inverse)
          o[127-8*(r+4*((c+r)%4)) -: 8] = inv_tab[s[127-8*(r+4*c) -: 8]];
        else
          o[127-8*(r+4*c) -: 8] = fwd_tab[s[127-8*(r+4*((c+r)%4)) -: 8]];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_block(logic [127:0] s, logic inverse);
    logic [127:0] o;
    logic [7:0]   coef[4];
    logic [7:0]   acc;
    o = '0;
    if (inverse) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++)
          acc ^= gf_mult(coef[(k-r+4)%4], s[127-8*(4*c+k) -: 8]);
        o[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] aes_transform(aes_pkg::cmd_e cmd, logic [127:0] key,
                                                 logic [127:0] blk);
    logic [127:0] rk[11];
    logic [31:0]  w0, w1, w2, w3, t;
    logic [7:0]   rc;
    logic [127:0] s;
    rk[0] = key;
    rc = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      {w0, w1, w2, w3} = rk[r-1];
      t = {fwd_tab[w3[23:16]] ^ rc, fwd_tab[w3[15:8]], fwd_tab[w3[7:0]],
           fwd_tab[w3[31:24]]};
      w0 ^= t;
      w1 ^= w0;
      w2 ^= w1;
      w3 ^= w2;
      rk[r] = {w0, w1, w2, w3};
      rc = gf_mult(rc, 8'h02);
    end
    s = blk;
    if (cmd == aes_pkg::CMD_ENCRYPT) begin
      s ^= rk[0];
      for (int r = 1; r < 10; r++) s = mix_block(sub_rows(s, 1'b0), 1'b0) ^ rk[r];
      s = sub_rows(s, 1'b0) ^ rk[10];
    end else begin
      s ^= rk[10];
      for (int r = 9; r > 0; r--) s = mix_block(sub_rows(s, 1'b1) ^ rk[r], 1'b1);
      s = sub_rows(s, 1'b1) ^ rk[0];
    end
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // Offer one item; hold valid until accepted, then log what it must produce.
  task automatic send_block(aes_pkg::cmd_e cmd, logic [63:0] hi, logic [63:0] lo,
                            logic known, logic [63:0] rhi, logic [63:0] rlo);
    cipher_out_t e;
    logic [127:0] r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    block_high_i <= hi;
    block_low_i  <= lo;
    do @(posedge clk_i); while (!in_ready_o);
    if (known) begin
      e.hi = rhi;
      e.lo = rlo;
    end else begin
      r = aes_transform(cmd, cur_key, {hi, lo});
      e.hi = r[127:64];
      e.lo = r[63:0];
    end
    pending_blocks.insert(pending_blocks.size(), e);
  endtask

  task automatic drain_and_rest();
    in_valid_i <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Write both key halves while idle, then let the key chain settle.
  task automatic load_key(logic [63:0] hi, logic [63:0] lo);
    drain_and_rest();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= aes_pkg::REG_KEY_HIGH;
    cfg_data_i  <= hi;
    @(posedge clk_i);
    cfg_index_i <= aes_pkg::REG_KEY_LOW;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_key = {hi, lo};
    repeat (16) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 300;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cipher_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch("unexpected item", result_high_o, result_low_o);
      end else begin
        e = pending_blocks.pop_front();
        if (result_high_o !== e.hi) report_mismatch("result_high", result_high_o, e.hi);
        if (result_low_o !== e.lo) report_mismatch("result_low", result_low_o, e.lo);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    vec_row_t vectors[$];
    int pct[3][2];
    vectors = '{
      '{1'b0, '0, '0, aes_pkg::CMD_ENCRYPT, '0, '0,
        1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{1'b0, '0, '0, aes_pkg::CMD_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e,
        1'b1, '0, '0},
      '{1'b0, '0, '0, aes_pkg::CMD_ENCRYPT, '1, '1, 1'b0, '0, '0},
      '{1'b0, '0, '0, aes_pkg::CMD_DECRYPT, '1, '1, 1'b0, '0, '0},
      '{1'b0, '0, '0, aes_pkg::CMD_ENCRYPT, {16{4'ha}}, {16{4'h5}}, 1'b0, '0, '0},
      '{1'b0, '0, '0, aes_pkg::CMD_DECRYPT, {16{4'h5}}, {16{4'ha}}, 1'b0, '0, '0},
      '{1'b1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, aes_pkg::CMD_ENCRYPT,
        64'h0011223344556677, 64'h8899aabbccddeeff,
        1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
      '{1'b0, '0, '0, aes_pkg::CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a,
        1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff},
      '{1'b1, '1, '1, aes_pkg::CMD_ENCRYPT, '0, '0, 1'b0, '0, '0},
      '{1'b0, '0, '0, aes_pkg::CMD_DECRYPT, '0, '0, 1'b0, '0, '0},
      '{1'b0, '0, '0, aes_pkg::CMD_ENCRYPT, '1, '1, 1'b0, '0, '0},
      '{1'b0, '0, '0, aes_pkg::CMD_DECRYPT, '1, '1, 1'b0, '0, '0},
      '{1'b1, '1, '0, aes_pkg::CMD_ENCRYPT, 64'h8000000000000000, 64'h1,
        1'b0, '0, '0},
      '{1'b0, '0, '0, aes_pkg::CMD_DECRYPT, 64'h1, 64'h8000000000000000,
        1'b0, '0, '0},
      '{1'b1, '0, '1, aes_pkg::CMD_ENCRYPT, {16{4'h5}}, {16{4'ha}}, 1'b0, '0, '0},
      '{1'b0, '0, '0, aes_pkg::CMD_DECRYPT, {16{4'ha}}, {16{4'h5}}, 1'b0, '0, '0}
    };
    pct = '{'{13, 51}, '{51, 13}, '{0, 0}};
    build_sub_tables();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vectors[i]) begin
      if (vectors[i].load_key) load_key(vectors[i].key_hi, vectors[i].key_lo);
      send_block(vectors[i].cmd, vectors[i].blk_hi, vectors[i].blk_lo,
                 vectors[i].known, vectors[i].res_hi, vectors[i].res_lo);
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = pct[ph][0];
      rx_idle_pct = pct[ph][1];
      for (int seg = 0; seg < 3; seg++) begin
        load_key({$urandom, $urandom}, {$urandom, $urandom});
        // Stall the output for a long stretch so the pipe backs up.
        if (seg == 1) hold_req++;
        for (int n = 0; n < 110; n++)
          send_block(aes_pkg::cmd_e'($urandom_range(1)), rand_word(), rand_word(),
                     1'b0, '0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/aes_pkg.sv
rtl/aes_key_sched.sv
rtl/aes_round.sv
rtl/aes128_block_cipher_core.sv
tb/aes128_block_cipher_core_tb.sv
